FILE: rtl/cde_pkg.sv
package cde_pkg;

  localparam int unsigned YR_W   = 15;
  localparam int unsigned DBY_W  = 24;
  localparam int unsigned CNT_W  = 24;
  localparam int unsigned REM_W  = 9;
  localparam int unsigned Q_W    = 9;
  localparam int unsigned BIT_W  = 4;

  localparam int unsigned YEAR_BITS_DEF = 15;

  // Reciprocal of 100: (x * 5243) >> 19 is exact for x below 43690.
  localparam int unsigned RECIP_W   = 13;
  localparam int unsigned RECIP_SH  = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  localparam logic [YR_W-1:0] GAP_YEAR    = 15'd1582;
  localparam logic [YR_W-1:0] JULIAN_LAST = 15'd1500;
  localparam logic [3:0]      GAP_MONTH   = 4'd10;
  localparam logic [3:0]      FEB         = 4'd2;
  localparam logic [3:0]      DEC         = 4'd12;

  localparam logic [2:0] MODE_VALIDATE = 3'd0;
  localparam logic [2:0] MODE_NEXT     = 3'd1;
  localparam logic [2:0] MODE_PREV     = 3'd2;
  localparam logic [2:0] MODE_COUNT    = 3'd3;
  localparam logic [2:0] MODE_TO_DATE  = 3'd4;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_YEAR = 3'd1;
  localparam logic [2:0] ERR_MLO  = 3'd2;
  localparam logic [2:0] ERR_MHI  = 3'd3;
  localparam logic [2:0] ERR_DLO  = 3'd4;
  localparam logic [2:0] ERR_DHI  = 3'd5;
  localparam logic [2:0] ERR_GAP  = 3'd6;
  localparam logic [2:0] ERR_OVF  = 3'd7;

  localparam logic [4:0] DIM [13] = '{5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
                                      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  localparam logic [8:0] DBM [13] = '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

  typedef struct packed {
    logic [2:0]  mode;
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] start_year;
    logic [21:0] day_number;
  } cde_in_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [14:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [23:0] day_count;
  } cde_out_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_CHECK,
    OP_COUNT,
    OP_BASE,
    OP_SEARCH,
    OP_REM,
    OP_MSTEP
  } dp_op_t;

  typedef enum logic [1:0] {
    YS_YEAR,
    YS_START,
    YS_CAND,
    YS_SY
  } ysel_t;

  typedef struct packed {
    dp_op_t op;
    ysel_t  ysel;
  } cde_cmd_t;

  typedef struct packed {
    logic is_num;
    logic count_go;
    logic base_done;
    logic last_bit;
    logic rem_sat;
    logic step_more;
  } cde_stat_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    if (m > DEC) begin
      len = 5'd0;
    end else if (m == FEB) begin
      len = lp ? 5'd29 : 5'd28;
    end else begin
      len = DIM[m];
    end
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] v;
    if (m > DEC) begin
      v = 9'd0;
    end else begin
      v = DBM[m];
    end
    return v;
  endfunction

endpackage

FILE: rtl/cde_year_unit.sv
module cde_year_unit import cde_pkg::*; (
  input  logic             clk,
  input  logic [YR_W-1:0]  yr_i,
  output logic [DBY_W-1:0] dby_o,
  output logic             leap_o
);

  localparam int unsigned PROD_W = YR_W + RECIP_W;

  logic [YR_W-1:0]   n_in;
  logic [PROD_W-1:0] qn_prod;
  logic [PROD_W-1:0] qy_prod;

  logic [YR_W-1:0]  y_r;
  logic [DBY_W-1:0] p365_r;
  logic [Q_W-1:0]   qn_r;
  logic [Q_W-1:0]   qy_r;

  logic [YR_W-1:0]  y_prev;
  logic [Q_W-1:0]   skip;
  logic [DBY_W-1:0] gap_adj;
  logic [YR_W-1:0]  ry_full;
  logic [6:0]       ry;

  assign n_in    = yr_i - YR_W'(1);
  assign qn_prod = PROD_W'(n_in) * PROD_W'(RECIP_100);
  assign qy_prod = PROD_W'(yr_i) * PROD_W'(RECIP_100);

  // First stage: the constant multiplications.
  always_ff @(posedge clk) begin
    y_r    <= yr_i;
    p365_r <= DBY_W'(yr_i) * DBY_W'(365);
    qn_r   <= qn_prod[RECIP_SH +: Q_W];
    qy_r   <= qy_prod[RECIP_SH +: Q_W];
  end

  // Days in all years before y: 365 per year, Julian leap days, minus the
  // Gregorian century years that skip a leap day, minus the ten gap days.
  always_comb begin
    y_prev = y_r - YR_W'(1);
    if (y_prev < JULIAN_LAST) begin
      skip = '0;
    end else begin
      skip = qn_r - (qn_r >> 2) - Q_W'(12);
    end
    gap_adj = (y_r > GAP_YEAR) ? DBY_W'(10) : '0;
    if (y_r == '0) begin
      dby_o = '0;
    end else begin
      dby_o = p365_r + DBY_W'(y_prev >> 2) + DBY_W'(1) - DBY_W'(skip) - gap_adj;
    end
    ry_full = y_r - YR_W'(qy_r) * YR_W'(100);
    ry      = ry_full[6:0];
    leap_o  = (y_r[1:0] == 2'b00) &&
              ((y_r <= JULIAN_LAST) || (ry != 7'd0) || (qy_r[1:0] == 2'b00));
  end

endmodule

FILE: rtl/cde_datapath.sv
module cde_datapath import cde_pkg::*; #(
  parameter int unsigned YEAR_BITS = YEAR_BITS_DEF
) (
  input  logic      clk,
  input  cde_in_t   in_data,
  input  cde_cmd_t  cmd,
  output cde_stat_t stat,
  output cde_out_t  res
);

  localparam int unsigned LimInt = (YEAR_BITS >= 15) ? 32767 : ((1 << YEAR_BITS) - 1);
  localparam logic [YR_W-1:0] LIM = LimInt[YR_W-1:0];

  cde_in_t           in_r, in_nxt;
  logic [DBY_W-1:0]  t_r, t_nxt;
  logic [YR_W-1:0]   sy_r, sy_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [3:0]        m_r, m_nxt;
  logic [DBY_W-1:0]  dy_r, dy_nxt;
  logic              leap_r, leap_nxt;
  cde_out_t          res_r, res_nxt;

  logic [YR_W-1:0]   yu_in;
  logic [DBY_W-1:0]  yu_dby;
  logic              yu_leap;
  logic [YR_W-1:0]   cand;
  logic [YR_W-1:0]   start_ext;

  logic [4:0]        ml_in;
  logic              gap_month;
  logic [2:0]        err_chk;
  logic [5:0]        nd;
  logic [4:0]        pd;
  cde_out_t          chk_res;
  cde_out_t          sat_res;

  logic [DBY_W-1:0]  span;
  logic [CNT_W:0]    cnt;
  logic              gap_late;
  logic [4:0]        ml_step;
  logic [REM_W-1:0]  rem_day;

  assign start_ext = YR_W'(in_r.start_year);
  assign cand      = sy_r | (YR_W'(1) << bit_r);

  always_comb begin
    unique case (cmd.ysel)
      YS_YEAR:  yu_in = in_r.year;
      YS_START: yu_in = start_ext;
      YS_CAND:  yu_in = cand;
      YS_SY:    yu_in = sy_r;
    endcase
  end

  cde_year_unit u_year (
    .clk    (clk),
    .yr_i   (yu_in),
    .dby_o  (yu_dby),
    .leap_o (yu_leap)
  );

  // Date check and one-day steps, used while the year unit holds leap(year).
  always_comb begin
    ml_in     = month_len(in_r.month, yu_leap);
    gap_month = (in_r.year == GAP_YEAR) && (in_r.month == GAP_MONTH);
    priority if (in_r.year == '0) begin
      err_chk = ERR_YEAR;
    end else if (in_r.month == 4'd0) begin
      err_chk = ERR_MLO;
    end else if (in_r.month > DEC) begin
      err_chk = ERR_MHI;
    end else if (in_r.day == 5'd0) begin
      err_chk = ERR_DLO;
    end else if (in_r.day > ml_in) begin
      err_chk = ERR_DHI;
    end else if (gap_month && (in_r.day > 5'd4) && (in_r.day < 5'd15)) begin
      err_chk = ERR_GAP;
    end else if (in_r.year > LIM) begin
      err_chk = ERR_OVF;
    end else begin
      err_chk = ERR_NONE;
    end

    nd = 6'(in_r.day) + 6'd1;
    if (gap_month && (nd == 6'd5)) begin
      nd = 6'd15;
    end
    pd = in_r.day - 5'd1;
    if (gap_month && (pd == 5'd14)) begin
      pd = 5'd4;
    end

    chk_res = '{error_code: err_chk, out_year: in_r.year, out_month: in_r.month,
                out_day: in_r.day, day_count: '0};
    if (err_chk == ERR_NONE && in_r.mode == MODE_NEXT) begin
      priority if (nd <= 6'(ml_in)) begin
        chk_res.out_day = nd[4:0];
      end else if (in_r.month < DEC) begin
        chk_res.out_month = in_r.month + 4'd1;
        chk_res.out_day   = 5'd1;
      end else if (in_r.year >= LIM) begin
        chk_res.error_code = ERR_OVF;
      end else begin
        chk_res.out_year  = in_r.year + YR_W'(1);
        chk_res.out_month = 4'd1;
        chk_res.out_day   = 5'd1;
      end
    end else if (err_chk == ERR_NONE && in_r.mode == MODE_PREV) begin
      priority if (pd != 5'd0) begin
        chk_res.out_day = pd;
      end else if (in_r.month > 4'd1) begin
        chk_res.out_month = in_r.month - 4'd1;
        chk_res.out_day   = month_len(in_r.month - 4'd1, yu_leap);
      end else if (in_r.year <= YR_W'(1)) begin
        chk_res.error_code = ERR_OVF;
      end else begin
        chk_res.out_year  = in_r.year - YR_W'(1);
        chk_res.out_month = DEC;
        chk_res.out_day   = 5'd31;
      end
    end
  end

  // Day count; the year unit now holds days before start_year.
  always_comb begin
    span     = (in_r.year > start_ext) ? (dy_r - yu_dby) : '0;
    gap_late = (in_r.year == GAP_YEAR) &&
               ((in_r.month > GAP_MONTH) || ((in_r.month == GAP_MONTH) && (in_r.day > 5'd14)));
    cnt = (CNT_W+1)'(span) + (CNT_W+1)'(days_before_month(in_r.month))
        + (CNT_W+1)'(leap_r && (in_r.month > FEB))
        - (gap_late ? (CNT_W+1)'(10) : '0) + (CNT_W+1)'(in_r.day);
  end

  always_comb begin
    ml_step = month_len(m_r, leap_r);
    rem_day = rem_r + REM_W'(1);
    sat_res = '{error_code: ERR_OVF, out_year: LIM, out_month: DEC, out_day: 5'd31,
                day_count: '0};
  end

  always_comb begin
    stat.is_num    = (in_r.mode == MODE_TO_DATE);
    stat.count_go  = (in_r.mode == MODE_COUNT) && (err_chk == ERR_NONE);
    stat.base_done = (start_ext > LIM) || (in_r.day_number == '0);
    stat.last_bit  = (bit_r == '0);
    stat.rem_sat   = (sy_r > LIM);
    stat.step_more = (m_r < DEC) && (rem_r >= REM_W'(ml_step));
  end

  always_comb begin
    in_nxt   = in_r;
    t_nxt    = t_r;
    sy_nxt   = sy_r;
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    m_nxt    = m_r;
    dy_nxt   = dy_r;
    leap_nxt = leap_r;
    res_nxt  = res_r;
    unique case (cmd.op)
      OP_IDLE: begin
      end
      OP_LOAD: begin
        in_nxt = in_data;
      end
      OP_CHECK: begin
        dy_nxt   = yu_dby;
        leap_nxt = yu_leap;
        res_nxt  = chk_res;
      end
      OP_COUNT: begin
        res_nxt = '{error_code: ERR_NONE, out_year: in_r.year, out_month: in_r.month,
                    out_day: in_r.day, day_count: cnt[CNT_W-1:0]};
        if (cnt[CNT_W]) begin
          res_nxt.error_code = ERR_OVF;
          res_nxt.day_count  = '1;
        end
      end
      OP_BASE: begin
        priority if (start_ext > LIM) begin
          res_nxt = sat_res;
        end else if (in_r.day_number == '0) begin
          res_nxt = '{error_code: ERR_DLO, out_year: start_ext, out_month: 4'd1,
                      out_day: 5'd0, day_count: '0};
        end else begin
          t_nxt   = yu_dby + DBY_W'(in_r.day_number) - DBY_W'(1);
          sy_nxt  = '0;
          bit_nxt = BIT_W'(YR_W - 1);
        end
      end
      OP_SEARCH: begin
        // Keep the candidate bit when that year still starts on or before t.
        if (yu_dby <= t_r) begin
          sy_nxt = cand;
        end
        bit_nxt = bit_r - BIT_W'(1);
      end
      OP_REM: begin
        if (sy_r > LIM) begin
          res_nxt = sat_res;
        end else begin
          rem_nxt  = REM_W'(t_r - yu_dby);
          leap_nxt = yu_leap;
          m_nxt    = 4'd1;
        end
      end
      OP_MSTEP: begin
        if (stat.step_more) begin
          rem_nxt = rem_r - REM_W'(ml_step);
          m_nxt   = m_r + 4'd1;
        end else begin
          res_nxt = '{error_code: ERR_NONE, out_year: sy_r, out_month: m_r,
                      out_day: rem_day[4:0], day_count: '0};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    t_r    <= t_nxt;
    sy_r   <= sy_nxt;
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    m_r    <= m_nxt;
    dy_r   <= dy_nxt;
    leap_r <= leap_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

FILE: rtl/cde_ctrl.sv
module cde_ctrl import cde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  cde_stat_t stat,
  output cde_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_COUNT,
    S_BASE,
    S_SISS,
    S_SCMP,
    S_RISS,
    S_REM,
    S_MSTEP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd.op        = OP_IDLE;
    cmd.ysel      = YS_YEAR;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.ysel  = stat.is_num ? YS_START : YS_YEAR;
        state_nxt = stat.is_num ? S_BASE : S_CHECK;
      end
      S_CHECK: begin
        // The start year goes into the year unit in case a count follows.
        cmd.op   = OP_CHECK;
        cmd.ysel = YS_START;
        if (stat.count_go) begin
          state_nxt = S_COUNT;
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      S_COUNT: begin
        cmd.op        = OP_COUNT;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      S_BASE: begin
        cmd.op = OP_BASE;
        if (stat.base_done) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_SISS;
        end
      end
      S_SISS: begin
        cmd.ysel  = YS_CAND;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.op    = OP_SEARCH;
        cmd.ysel  = YS_CAND;
        state_nxt = stat.last_bit ? S_RISS : S_SISS;
      end
      S_RISS: begin
        cmd.ysel  = YS_SY;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.op = OP_REM;
        if (stat.rem_sat) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_MSTEP;
        end
      end
      S_MSTEP: begin
        cmd.op = OP_MSTEP;
        if (!stat.step_more) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/calendar_date_engine.sv
// Calendar date engine (Julian leap rule through 1500, Gregorian after, with
// October 5 to 14 of 1582 missing). An item is taken when start is high
// and busy is low; its result appears on out_data for exactly one cycle,
// marked by out_valid, and must be captured in that cycle because the block
// cannot be held off. Validate, next day and previous day pass through the
// PREP and CHECK states, a day count adds COUNT, and day number to date runs
// PREP and BASE, then a 15-step bitwise search over the year, each step in
// SISS and SCMP via the shared days-before-year unit, then RISS, REM, MSTEP.
// busy drops in the cycle in which out_valid is shown, so the next item can
// be accepted there.
module calendar_date_engine import cde_pkg::*; #(
  parameter int unsigned YEAR_BITS = YEAR_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cde_in_t  in_data,
  output logic     out_valid,
  output cde_out_t out_data
);

  cde_cmd_t  cmd;
  cde_stat_t stat;

  cde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cde_datapath #(
    .YEAR_BITS (YEAR_BITS)
  ) u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .res     (out_data)
  );

endmodule

FILE: tb/tb_calendar_date_engine.sv
`timescale 1ns / 1ps

module tb_calendar_date_engine;
  import cde_pkg::*;

  localparam longint unsigned YEAR_LIM =
    ((64'd1 << YEAR_BITS_DEF) - 1) < 64'd32767 ? ((64'd1 << YEAR_BITS_DEF) - 1) : 64'd32767;
  localparam longint unsigned COUNT_SAT    = 64'hFF_FFFF;
  localparam longint unsigned GAP_YEAR_LEN = 355;
  localparam longint unsigned GAP_FIRST    = 5;
  localparam longint unsigned GAP_LAST     = 14;
  localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;
  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam int unsigned SETTLE_CYCLES = 50;
  localparam int unsigned IN_W          = $bits(cde_in_t);

  localparam int unsigned PLAIN_LEN [13] = '{0, 31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned CUM_DAYS [13]  = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                             304, 334};

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cde_in_t  in_data;
  logic     out_valid;
  cde_out_t out_data;

  cde_out_t    predicted_dates[$];
  int unsigned fault_count;
  int unsigned results_checked;
  int unsigned beats_by_mode[8];
  int unsigned errs_seen[8];

  calendar_date_engine u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit leap_year(input longint unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y <= JULIAN_LAST) return 1'b1;
    if (y % 100 == 0) return (y % 400 == 0);
    return 1'b1;
  endfunction

  function automatic longint unsigned month_days(input longint unsigned y,
                                                 input longint unsigned m);
    if (m == 0 || m > DEC) return 0;
    if (m == FEB) return leap_year(y) ? 29 : 28;
    return PLAIN_LEN[int'(m)];
  endfunction

  // Days in all years before y, with the ten lost days of the gap year.
  function automatic longint unsigned days_to_year(input longint unsigned y);
    longint unsigned n;
    longint unsigned dropped;
    longint unsigned e;
    if (y == 0) return 0;
    n = y - 1;
    dropped = (n < JULIAN_LAST) ? 0 : (n / 100 - 15) - (n / 400 - 3);
    e = 365 * y + n / 4 + 1 - dropped;
    if (y > GAP_YEAR) e -= 10;
    return e;
  endfunction

  function automatic logic [2:0] date_error(input longint unsigned y,
                                            input longint unsigned m,
                                            input longint unsigned d);
    if (y == 0) return ERR_YEAR;
    if (m == 0) return ERR_MLO;
    if (m > DEC) return ERR_MHI;
    if (d < 1) return ERR_DLO;
    if (d > month_days(y, m)) return ERR_DHI;
    if (y == GAP_YEAR && m == GAP_MONTH && d >= GAP_FIRST && d <= GAP_LAST) return ERR_GAP;
    if (y > YEAR_LIM) return ERR_OVF;
    return ERR_NONE;
  endfunction

  function automatic cde_out_t predict_date(input cde_in_t b);
    longint unsigned y, m, d, sy, num, cnt, t, lo, hi, mid, rem, nd, pd;
    logic [2:0] err;
    cde_out_t r;
    y   = b.year;
    m   = b.month;
    d   = b.day;
    sy  = b.start_year;
    num = b.day_number;
    cnt = 0;
    err = ERR_NONE;
    if (b.mode == MODE_TO_DATE) begin
      if (sy > YEAR_LIM) begin
        err = ERR_OVF; y = YEAR_LIM; m = DEC; d = 31;
      end else if (num == 0) begin
        err = ERR_DLO; y = sy; m = 1; d = 0;
      end else begin
        t  = days_to_year(sy) + num - 1;
        lo = sy;
        hi = t / GAP_YEAR_LEN + 1;
        while (lo < hi) begin
          mid = lo + (hi - lo + 1) / 2;
          if (days_to_year(mid) <= t) lo = mid;
          else hi = mid - 1;
        end
        if (lo > YEAR_LIM) begin
          err = ERR_OVF; y = YEAR_LIM; m = DEC; d = 31;
        end else begin
          // Months are stepped with plain lengths; the gap is not skipped here.
          y   = lo;
          rem = t - days_to_year(y);
          m   = 1;
          while (m < DEC && rem >= month_days(y, m)) begin
            rem -= month_days(y, m);
            m++;
          end
          d = rem + 1;
        end
      end
    end else begin
      err = date_error(y, m, d);
      if (err == ERR_NONE) begin
        case (b.mode)
          MODE_NEXT: begin
            nd = d + 1;
            if (y == GAP_YEAR && m == GAP_MONTH && nd == GAP_FIRST) nd = GAP_LAST + 1;
            if (nd <= month_days(y, m)) begin
              d = nd;
            end else if (m < DEC) begin
              m++; d = 1;
            end else if (y >= YEAR_LIM) begin
              err = ERR_OVF;
            end else begin
              y++; m = 1; d = 1;
            end
          end
          MODE_PREV: begin
            pd = d - 1;
            if (y == GAP_YEAR && m == GAP_MONTH && pd == GAP_LAST) pd = GAP_FIRST - 1;
            if (pd > 0) begin
              d = pd;
            end else if (m > 1) begin
              m--; d = month_days(y, m);
            end else if (y <= 1) begin
              err = ERR_OVF;
            end else begin
              y--; m = DEC; d = 31;
            end
          end
          MODE_COUNT: begin
            if (y > sy) cnt = days_to_year(y) - days_to_year(sy);
            cnt += CUM_DAYS[int'(m)];
            if (leap_year(y) && m > FEB) cnt++;
            if (y == GAP_YEAR && (m > GAP_MONTH || (m == GAP_MONTH && d > GAP_LAST))) cnt -= 10;
            cnt += d;
            if (cnt > COUNT_SAT) begin
              cnt = COUNT_SAT;
              err = ERR_OVF;
            end
          end
          default: ;
        endcase
      end
    end
    r.error_code = err;
    r.out_year   = 15'(y);
    r.out_month  = 4'(m);
    r.out_day    = 5'(d);
    r.day_count  = 24'(cnt);
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic cde_in_t mk(input logic [2:0] mode, input logic [14:0] y,
                                 input logic [3:0] m, input logic [4:0] d,
                                 input logic [13:0] sy, input logic [21:0] num);
    cde_in_t b;
    b.mode       = mode;
    b.year       = y;
    b.month      = m;
    b.day        = d;
    b.start_year = sy;
    b.day_number = num;
    return b;
  endfunction

  task automatic issue_date_op(input cde_in_t b);
    cde_out_t want;
    @(negedge clk);
    start   = 1'b1;
    in_data = b;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    want = predict_date(b);
    predicted_dates = {predicted_dates, want};
    beats_by_mode[b.mode]++;
    errs_seen[want.error_code]++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start   = 1'b0;
      in_data = IN_W'({$urandom, $urandom});
    end
  endtask

  task automatic wait_all_done();
    pause_sender(1);
    while (predicted_dates.size() != 0) @(posedge clk);
  endtask

  function automatic cde_in_t rand_item();
    cde_in_t b;
    int unsigned r;
    longint unsigned len;
    if ($urandom_range(0, 6) == 0) begin
      b = IN_W'({$urandom, $urandom});
      return b;
    end
    r = $urandom_range(0, 10);
    b.mode = (r < 10) ? 3'(r % 5) : 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    case ($urandom_range(0, 8))
      0:       b.year = 15'($urandom_range(1, 12));
      1:       b.year = 15'($urandom_range(1490, 1510));
      2:       b.year = 15'($urandom_range(1575, 1590));
      3:       b.year = 15'($urandom_range(15, 327) * 100);
      4:       b.year = 15'($urandom_range(32700, 32767));
      5:       b.year = 15'($urandom_range(1900, 2100));
      6:       b.year = GAP_YEAR;
      default: b.year = 15'($urandom_range(1, 32767));
    endcase
    b.month = 4'($urandom_range(1, 12));
    if (b.year == GAP_YEAR && $urandom_range(0, 1) == 1) b.month = GAP_MONTH;
    len = month_days(b.year, b.month);
    // Month ends and the days around the gap are where stepping gets interesting.
    case ($urandom_range(0, 4))
      0:       b.day = 5'd1;
      1:       b.day = 5'(len);
      2:       b.day = 5'(len - 1);
      3:       b.day = 5'($urandom_range(GAP_FIRST - 1, GAP_LAST + 1));
      default: b.day = 5'($urandom_range(1, len));
    endcase
    case ($urandom_range(0, 4))
      0:       b.start_year = 14'($urandom_range(1, 20));
      1:       b.start_year = 14'($urandom_range(1490, 1600));
      2:       b.start_year = 14'($urandom);
      3:       b.start_year = (b.year > 60) ? 14'(b.year - $urandom_range(0, 60)) : 14'd1;
      default: b.start_year = 14'($urandom_range(1900, 2100));
    endcase
    r = $urandom_range(0, 15);
    if (r == 0) b.day_number = '0;
    else if (r < 6) b.day_number = 22'($urandom_range(1, 800));
    else if (r < 11) b.day_number = 22'($urandom_range(1, 800000));
    else b.day_number = 22'($urandom);
    return b;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : result_check
    cde_out_t want;
    if (rst_n && out_valid) begin
      if (predicted_dates.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: result with nothing pending: err=%0d %0d-%0d-%0d count=%0d",
                   $realtime, out_data.error_code, out_data.out_year, out_data.out_month,
                   out_data.out_day, out_data.day_count);
      end else begin
        want = predicted_dates.pop_front();
        results_checked++;
        if (out_data.error_code !== want.error_code || out_data.out_year !== want.out_year ||
            out_data.out_month !== want.out_month || out_data.out_day !== want.out_day ||
            out_data.day_count !== want.day_count) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: mismatch: expected err=%0d %0d-%0d-%0d count=%0d",
                     $realtime, want.error_code, want.out_year, want.out_month,
                     want.out_day, want.day_count);
            $display("%0t:           got err=%0d %0d-%0d-%0d count=%0d",
                     $realtime, out_data.error_code, out_data.out_year,
                     out_data.out_month, out_data.out_day, out_data.day_count);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_check_dates();
    issue_date_op(mk(MODE_VALIDATE, 15'd0, 4'd1, 5'd1, 14'd1, 22'd0));
    issue_date_op(mk(MODE_VALIDATE, 15'd2000, 4'd0, 5'd5, 14'd1, 22'd0));
    issue_date_op(mk(MODE_VALIDATE, 15'd1999, 4'd15, 5'd31, 14'd1, 22'd0));
    issue_date_op(mk(MODE_VALIDATE, 15'd1999, 4'd2, 5'd0, 14'd1, 22'd0));
    issue_date_op(mk(MODE_VALIDATE, 15'd1900, 4'd2, 5'd29, 14'd1, 22'd0));
    issue_date_op(mk(MODE_VALIDATE, 15'd1500, 4'd2, 5'd29, 14'd1, 22'd0));
    issue_date_op(mk(MODE_VALIDATE, 15'd1582, 4'd10, 5'd10, 14'd1, 22'd0));
    issue_date_op(mk(MODE_UNUSED_HI, 15'd32767, 4'd12, 5'd31, 14'd16383, 22'h3F_FFFF));
    issue_date_op(mk(MODE_UNUSED_LO, 15'd2023, 4'd4, 5'd31, 14'd1, 22'd0));
  endtask

  task automatic test_day_steps();
    issue_date_op(mk(MODE_NEXT, 15'd1582, 4'd10, 5'd4, 14'd1, 22'd0));
    issue_date_op(mk(MODE_NEXT, 15'd32767, 4'd12, 5'd31, 14'd1, 22'd0));
    issue_date_op(mk(MODE_NEXT, 15'd1999, 4'd12, 5'd31, 14'd1, 22'd0));
    issue_date_op(mk(MODE_NEXT, 15'd2024, 4'd2, 5'd28, 14'd1, 22'd0));
    issue_date_op(mk(MODE_PREV, 15'd1582, 4'd10, 5'd15, 14'd1, 22'd0));
    issue_date_op(mk(MODE_PREV, 15'd1, 4'd1, 5'd1, 14'd1, 22'd0));
    issue_date_op(mk(MODE_PREV, 15'd2000, 4'd3, 5'd1, 14'd1, 22'd0));
    issue_date_op(mk(MODE_PREV, 15'd1700, 4'd3, 5'd1, 14'd1, 22'd0));
  endtask

  task automatic test_day_counts();
    issue_date_op(mk(MODE_COUNT, 15'd32767, 4'd12, 5'd31, 14'd1, 22'd0));
    issue_date_op(mk(MODE_COUNT, 15'd1582, 4'd12, 5'd31, 14'd1582, 22'd0));
    // A year before the epoch only counts the days within that year.
    issue_date_op(mk(MODE_COUNT, 15'd100, 4'd7, 5'd4, 14'd16383, 22'd0));
    issue_date_op(mk(MODE_COUNT, 15'd2001, 4'd2, 5'd29, 14'd1, 22'd0));
  endtask

  task automatic test_number_to_date();
    issue_date_op(mk(MODE_TO_DATE, 15'd0, 4'd0, 5'd0, 14'd16383, 22'd0));
    issue_date_op(mk(MODE_TO_DATE, 15'd0, 4'd0, 5'd0, 14'd16383, 22'h3F_FFFF));
    issue_date_op(mk(MODE_TO_DATE, 15'd0, 4'd0, 5'd0, 14'd1, 22'd1));
    issue_date_op(mk(MODE_TO_DATE, 15'd0, 4'd0, 5'd0, 14'd1582, 22'd300));
    issue_date_op(mk(MODE_TO_DATE, 15'd0, 4'd0, 5'd0, 14'd1, 22'h3F_FFFF));
  endtask

  task automatic test_random_mix();
    int unsigned left;
    int unsigned burst;
    left = RANDOM_ITEMS;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && left > 0) begin
        issue_date_op(rand_item());
        burst--;
        left--;
      end
      if ($urandom_range(0, 24) == 0) wait_all_done();
      else if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_data         = '0;
    fault_count     = 0;
    results_checked = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_check_dates();
    test_day_steps();
    wait_all_done();
    test_day_counts();
    test_number_to_date();
    wait_all_done();
    test_random_mix();

    wait_all_done();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d validate, %0d next, %0d previous,",
             results_checked, beats_by_mode[MODE_VALIDATE], beats_by_mode[MODE_NEXT],
             beats_by_mode[MODE_PREV]);
    $display("  %0d count, %0d to-date, %0d other-mode beats.",
             beats_by_mode[MODE_COUNT], beats_by_mode[MODE_TO_DATE],
             beats_by_mode[MODE_UNUSED_LO] + beats_by_mode[MODE_UNUSED_MID] +
             beats_by_mode[MODE_UNUSED_HI]);
    $display("Error codes predicted: ok %0d, year %0d, month %0d/%0d,",
             errs_seen[ERR_NONE], errs_seen[ERR_YEAR], errs_seen[ERR_MLO],
             errs_seen[ERR_MHI]);
    $display("  day %0d/%0d, gap %0d, overflow %0d.",
             errs_seen[ERR_DLO], errs_seen[ERR_DHI], errs_seen[ERR_GAP], errs_seen[ERR_OVF]);
    if (fault_count > 10) $display("%0d mismatches in total.", fault_count);
    if (fault_count == 0 && predicted_dates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cde_pkg.sv
rtl/cde_year_unit.sv
rtl/cde_datapath.sv
rtl/cde_ctrl.sv
rtl/calendar_date_engine.sv
tb/tb_calendar_date_engine.sv
